@@ rtl/tfn_pkg.sv @@
// Shared constants and types of the triangle face normal unit.
package tfn_pkg;

  localparam int VERTEX_DEPTH = 4096;
  localparam int COORD_BITS   = 24;
  localparam int FIELD_W      = 24;
  localparam int IDX_W        = 13;
  localparam int ADDR_W       = $clog2(VERTEX_DEPTH);
  localparam int CNT_W        = $clog2(VERTEX_DEPTH + 1);
  localparam int CMP_W        = (IDX_W > CNT_W) ? IDX_W : CNT_W;
  localparam int EDGE_W       = COORD_BITS + 1;
  localparam int PROD_W       = 2 * EDGE_W;
  localparam int CROSS_W      = PROD_W + 1;
  localparam int MAG_W        = (CROSS_W > 31) ? CROSS_W : 31;
  localparam int NM_W         = 30;
  localparam int SQ_W         = 64;
  localparam int ROOT_STEPS   = 32;
  localparam int ROOT_W       = 31;
  localparam int FRAC_SH      = 14;
  localparam int QUO_W        = 15;
  localparam int NUM_W        = NM_W + FRAC_SH + 1;
  localparam int REM_W        = ROOT_W + 1;
  localparam int VERT_W       = 3 * COORD_BITS;

  localparam logic FUNC_VERTEX = 1'b0;
  localparam logic FUNC_FACE   = 1'b1;
  localparam logic KIND_NORMAL = 1'b0;
  localparam logic KIND_VERTEX = 1'b1;

  typedef struct packed {
    logic                      func;
    logic signed [FIELD_W-1:0] coord_x;
    logic signed [FIELD_W-1:0] coord_y;
    logic signed [FIELD_W-1:0] coord_z;
    logic [IDX_W-1:0]          index_a;
    logic [IDX_W-1:0]          index_b;
    logic [IDX_W-1:0]          index_c;
  } in_item_t;

  typedef struct packed {
    logic                      kind;
    logic signed [FIELD_W-1:0] out_x;
    logic signed [FIELD_W-1:0] out_y;
    logic signed [FIELD_W-1:0] out_z;
    logic                      bad_face;
    logic                      last;
  } out_item_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] z;
  } vertex_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx_a;
    logic [IDX_W-1:0] idx_b;
    logic [IDX_W-1:0] idx_c;
    logic [CNT_W-1:0] count;
  } face_t;

endpackage

@@ rtl/tfn_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module tfn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/tfn_queue.sv @@
// Two-entry queue of face requests between front and back end.
module tfn_queue import tfn_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  face_t push_data,
  input  logic  pop,
  output face_t head,
  output logic  empty,
  output logic  full
);

  face_t      mem_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;

  assign empty = (cnt_r == 2'd0);
  assign full  = (cnt_r == 2'd2);
  assign head  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_data;
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

@@ rtl/tfn_front.sv @@
// Front end: accepts beats, appends vertices, queues face requests.
module tfn_front import tfn_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  in_item_t          in_item,
  input  logic              q_full,
  output logic              q_push,
  output face_t             q_data,
  output logic              ram_we,
  output logic [ADDR_W-1:0] ram_waddr,
  output vertex_t           ram_wdata
);

  logic             accept;
  logic [CNT_W-1:0] count_r;

  assign busy      = q_full;
  assign accept    = start && !q_full;
  assign ram_we    = accept && (in_item.func == FUNC_VERTEX)
                     && (count_r < CNT_W'(VERTEX_DEPTH));
  assign ram_waddr = count_r[ADDR_W-1:0];
  assign ram_wdata.x = COORD_BITS'(in_item.coord_x);
  assign ram_wdata.y = COORD_BITS'(in_item.coord_y);
  assign ram_wdata.z = COORD_BITS'(in_item.coord_z);

  assign q_push       = accept && (in_item.func == FUNC_FACE);
  assign q_data.idx_a = in_item.index_a;
  assign q_data.idx_b = in_item.index_b;
  assign q_data.idx_c = in_item.index_c;
  assign q_data.count = count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (ram_we) begin
      count_r <= count_r + CNT_W'(1);
    end
  end

endmodule

@@ rtl/tfn_back.sv @@
// Back end: fetches a face, forms the cross product, normalises, emits four beats.
module tfn_back import tfn_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  face_t             head,
  input  logic              q_empty,
  output logic              q_pop,
  output logic [ADDR_W-1:0] ram_raddr,
  input  vertex_t           ram_rdata,
  output logic              out_valid,
  output out_item_t         out_item
);

  typedef enum logic [3:0] {
    S_IDLE, S_FETCH, S_EDGE, S_CROSS, S_MAG, S_SCAN, S_SQ, S_ROOT, S_DIV, S_EMIT
  } state_t;

  state_t                     state_r;
  logic [5:0]                 step_r;
  face_t                      face_r;
  logic [2:0]                 ok_r;
  logic                       bad_r;
  vertex_t                    p_r [3];
  logic signed [EDGE_W-1:0]   e1_r [3];
  logic signed [EDGE_W-1:0]   e2_r [3];
  logic signed [PROD_W-1:0]   hold_r;
  logic signed [CROSS_W-1:0]  n_r [3];
  logic [2:0]                 neg_r;
  logic [MAG_W-1:0]           m_r [3];
  logic [SQ_W-1:0]            sum_r;
  logic [SQ_W-1:0]            x_r;
  logic [SQ_W-1:0]            r_r;
  logic [SQ_W-1:0]            bit_r;
  logic [REM_W-1:0]           rem_r [3];
  logic [QUO_W-1:0]           lo_r [3];
  logic [QUO_W-1:0]           q_r [3];
  logic                       out_valid_r;
  out_item_t                  out_item_r;

  logic [IDX_W-1:0]           idx_sel;
  logic signed [EDGE_W-1:0]   mul_a;
  logic signed [EDGE_W-1:0]   mul_b;
  logic signed [PROD_W-1:0]   prod;
  logic signed [CROSS_W-1:0]  diff;
  logic [CROSS_W-1:0]         nab [3];
  logic [MAG_W-1:0]           top;
  logic [NM_W-1:0]            m30 [3];
  logic [2*NM_W-1:0]          sq;
  logic [SQ_W-1:0]            rb;
  logic [ROOT_W-1:0]          d;
  logic [NUM_W-1:0]           num [3];
  logic [REM_W-1:0]           rem2 [3];
  logic [2:0]                 ge;
  logic [2:0]                 ok_new;
  logic signed [FIELD_W-1:0]  nrm [3];
  vertex_t                    pv;

  assign q_pop     = (state_r == S_IDLE) && !q_empty;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign ok_new[0] = (head.idx_a != '0) && (CMP_W'(head.idx_a) <= CMP_W'(head.count));
  assign ok_new[1] = (head.idx_b != '0) && (CMP_W'(head.idx_b) <= CMP_W'(head.count));
  assign ok_new[2] = (head.idx_c != '0) && (CMP_W'(head.idx_c) <= CMP_W'(head.count));

  always_comb begin
    case (step_r[1:0])
      2'd0:    idx_sel = face_r.idx_a;
      2'd1:    idx_sel = face_r.idx_b;
      default: idx_sel = face_r.idx_c;
    endcase
  end
  assign ram_raddr = ADDR_W'(idx_sel - IDX_W'(1));

  always_comb begin
    case (step_r[2:0])
      3'd0:    begin mul_a = e1_r[1]; mul_b = e2_r[2]; end
      3'd1:    begin mul_a = e1_r[2]; mul_b = e2_r[1]; end
      3'd2:    begin mul_a = e2_r[0]; mul_b = e1_r[2]; end
      3'd3:    begin mul_a = e2_r[2]; mul_b = e1_r[0]; end
      3'd4:    begin mul_a = e2_r[1]; mul_b = e1_r[0]; end
      default: begin mul_a = e2_r[0]; mul_b = e1_r[1]; end
    endcase
  end
  assign prod = mul_a * mul_b;
  assign diff = CROSS_W'(hold_r) - CROSS_W'(prod);

  assign top = m_r[0] | m_r[1] | m_r[2];
  assign sq  = m30[step_r[1:0]] * m30[step_r[1:0]];
  assign rb  = r_r + bit_r;
  assign d   = r_r[ROOT_W-1:0];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      nab[j]  = n_r[j][CROSS_W-1] ? CROSS_W'(-n_r[j]) : CROSS_W'(n_r[j]);
      m30[j]  = m_r[j][MAG_W-1 -: NM_W];
      num[j]  = {1'b0, m30[j], FRAC_SH'(0)} + NUM_W'(d >> 1);
      rem2[j] = {rem_r[j][REM_W-2:0], lo_r[j][QUO_W-1]};
      ge[j]   = rem2[j] >= REM_W'(d);
      nrm[j]  = neg_r[j] ? -FIELD_W'(q_r[j]) : FIELD_W'(q_r[j]);
    end
  end

  always_comb begin
    case (step_r[1:0])
      2'd1:    pv = p_r[0];
      2'd2:    pv = p_r[1];
      default: pv = p_r[2];
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (q_pop) begin
            face_r  <= head;
            ok_r    <= ok_new;
            bad_r   <= ~&ok_new;
            step_r  <= '0;
            state_r <= S_FETCH;
          end
        end
        S_FETCH: begin
          case (step_r[1:0])
            2'd1:    p_r[0] <= ok_r[0] ? ram_rdata : '0;
            2'd2:    p_r[1] <= ok_r[1] ? ram_rdata : '0;
            2'd3:    p_r[2] <= ok_r[2] ? ram_rdata : '0;
            default: ;
          endcase
          if (step_r == 6'd3) begin
            step_r  <= '0;
            state_r <= bad_r ? S_EMIT : S_EDGE;
          end else begin
            step_r <= step_r + 6'd1;
          end
        end
        S_EDGE: begin
          e1_r[0] <= EDGE_W'(p_r[0].x) - EDGE_W'(p_r[1].x);
          e1_r[1] <= EDGE_W'(p_r[0].y) - EDGE_W'(p_r[1].y);
          e1_r[2] <= EDGE_W'(p_r[0].z) - EDGE_W'(p_r[1].z);
          e2_r[0] <= EDGE_W'(p_r[0].x) - EDGE_W'(p_r[2].x);
          e2_r[1] <= EDGE_W'(p_r[0].y) - EDGE_W'(p_r[2].y);
          e2_r[2] <= EDGE_W'(p_r[0].z) - EDGE_W'(p_r[2].z);
          state_r <= S_CROSS;
        end
        S_CROSS: begin
          if (!step_r[0]) begin
            hold_r <= prod;
          end else begin
            n_r[step_r[2:1]] <= diff;
          end
          if (step_r == 6'd5) begin
            step_r  <= '0;
            state_r <= S_MAG;
          end else begin
            step_r <= step_r + 6'd1;
          end
        end
        S_MAG: begin
          for (int j = 0; j < 3; j++) begin
            m_r[j]   <= MAG_W'(nab[j]);
            neg_r[j] <= n_r[j][CROSS_W-1];
          end
          if ((nab[0] | nab[1] | nab[2]) == '0) begin
            bad_r   <= 1'b1;
            state_r <= S_EMIT;
          end else begin
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (top[MAG_W-1]) begin
            sum_r   <= '0;
            step_r  <= '0;
            state_r <= S_SQ;
          end else if (top[MAG_W-1 -: 8] == 8'd0) begin
            for (int j = 0; j < 3; j++) m_r[j] <= m_r[j] << 8;
          end else begin
            for (int j = 0; j < 3; j++) m_r[j] <= m_r[j] << 1;
          end
        end
        S_SQ: begin
          sum_r <= sum_r + SQ_W'(sq);
          if (step_r == 6'd2) begin
            x_r     <= sum_r + SQ_W'(sq);
            r_r     <= '0;
            bit_r   <= SQ_W'(1) << (SQ_W - 2);
            step_r  <= '0;
            state_r <= S_ROOT;
          end else begin
            step_r <= step_r + 6'd1;
          end
        end
        S_ROOT: begin
          if (x_r >= rb) begin
            x_r <= x_r - rb;
            r_r <= (r_r >> 1) + bit_r;
          end else begin
            r_r <= r_r >> 1;
          end
          bit_r <= bit_r >> 2;
          if (step_r == 6'(ROOT_STEPS - 1)) begin
            step_r  <= '0;
            state_r <= S_DIV;
          end else begin
            step_r <= step_r + 6'd1;
          end
        end
        S_DIV: begin
          for (int j = 0; j < 3; j++) begin
            if (step_r == 6'd0) begin
              rem_r[j] <= REM_W'(num[j][NUM_W-1:QUO_W]);
              lo_r[j]  <= num[j][QUO_W-1:0];
              q_r[j]   <= '0;
            end else begin
              rem_r[j] <= ge[j] ? rem2[j] - REM_W'(d) : rem2[j];
              lo_r[j]  <= lo_r[j] << 1;
              q_r[j]   <= {q_r[j][QUO_W-2:0], ge[j]};
            end
          end
          if (step_r == 6'(QUO_W)) begin
            step_r  <= '0;
            state_r <= S_EMIT;
          end else begin
            step_r <= step_r + 6'd1;
          end
        end
        S_EMIT: begin
          out_valid_r         <= 1'b1;
          out_item_r.bad_face <= bad_r;
          out_item_r.last     <= (step_r == 6'd3);
          if (step_r == 6'd0) begin
            out_item_r.kind  <= KIND_NORMAL;
            out_item_r.out_x <= bad_r ? '0 : nrm[0];
            out_item_r.out_y <= bad_r ? '0 : nrm[1];
            out_item_r.out_z <= bad_r ? '0 : nrm[2];
          end else begin
            out_item_r.kind  <= KIND_VERTEX;
            out_item_r.out_x <= FIELD_W'(pv.x);
            out_item_r.out_y <= FIELD_W'(pv.y);
            out_item_r.out_z <= FIELD_W'(pv.z);
          end
          if (step_r == 6'd3) begin
            step_r  <= '0;
            state_r <= S_IDLE;
          end else begin
            step_r <= step_r + 6'd1;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_last_ends_face: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.last |=> !out_valid)
    else $error("beat follows the last beat of a face");

  a_normal_then_vertex: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.kind == KIND_NORMAL) |=>
      out_valid && (out_item.kind == KIND_VERTEX))
    else $error("normal beat not followed by a vertex beat");

  a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (r_r != '0))
    else $error("zero divisor in normalisation");

endmodule

@@ rtl/triangle_face_normal_unit.sv @@
// Top level of the triangle face normal unit.
//
// Input channel: an item is taken when start is high and busy is low.
// A vertex item (func 0) is appended to the vertex store and gives no
// result; once the store is full further vertices are dropped.
// A face item (func 1) names three 1-based vertices and gives four result
// beats on out_item, each marked by out_valid for exactly one cycle: the
// unit normal in Q1.14, then vertices a, b and c, the last one flagged.
// Invalid indices or a zero-length normal give a zero normal and bad_face.
// Faces wait in a two-entry queue; busy rises only when it is full.
// A face is processed by vertex fetch, cross product on one shared
// multiplier, normalising shift, sums of squares, a 32-step square root
// and dividers in three lanes; four beats follow. The back end takes one
// face at a time while the queue accepts the next; vertices go in one a
// cycle while busy is low.
// Reset clears the vertex count and all control state; store contents are
// not cleared and need no clearing pass. The receiver cannot stall.
module triangle_face_normal_unit import tfn_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  logic              q_full;
  logic              q_empty;
  logic              q_push;
  logic              q_pop;
  face_t             q_data;
  face_t             q_head;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [ADDR_W-1:0] ram_raddr;
  vertex_t           ram_wdata;
  logic [VERT_W-1:0] ram_rdata;

  tfn_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_data),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata)
  );

  tfn_ram #(
    .WIDTH (VERT_W),
    .DEPTH (VERTEX_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  tfn_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_data),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty),
    .full      (q_full)
  );

  tfn_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (q_head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .ram_raddr (ram_raddr),
    .ram_rdata (vertex_t'(ram_rdata)),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

@@ tb/triangle_face_normal_unit_tb.sv @@
// Self-checking testbench of the triangle face normal unit.
module triangle_face_normal_unit_tb import tfn_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 100;

  class face_normal_board;
    vertex_t   store [VERTEX_DEPTH];
    int        count;
    out_item_t awaited[$];
    int        errors;

    function new();
      count = 0;
      errors = 0;
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask

    function automatic longint unsigned root64(longint unsigned x);
      longint unsigned r, bit_v;
      r = 0;
      bit_v = 64'd1 << 62;
      while (bit_v > x) bit_v >>= 2;
      while (bit_v != 0) begin
        if (x >= r + bit_v) begin
          x -= r + bit_v;
          r = (r >> 1) + bit_v;
        end else begin
          r >>= 1;
        end
        bit_v >>= 2;
      end
      return r;
    endfunction

    function automatic void note_input(in_item_t it);
      longint    p[3][3];
      longint    n[3];
      longint    e1[3], e2[3];
      longint unsigned m[3], mx, sum, d, q;
      logic [IDX_W-1:0] idx[3];
      bit        bad;
      int        hb;
      out_item_t r;
      if (it.func == FUNC_VERTEX) begin
        if (count < VERTEX_DEPTH) begin
          store[count] = '{it.coord_x, it.coord_y, it.coord_z};
          count++;
        end
        return;
      end
      idx = '{it.index_a, it.index_b, it.index_c};
      bad = 0;
      for (int i = 0; i < 3; i++) begin
        if (idx[i] >= 1 && idx[i] <= count) begin
          p[i][0] = store[idx[i]-1].x;
          p[i][1] = store[idx[i]-1].y;
          p[i][2] = store[idx[i]-1].z;
        end else begin
          p[i] = '{0, 0, 0};
          bad = 1;
        end
      end
      for (int j = 0; j < 3; j++) begin
        e1[j] = p[0][j] - p[1][j];
        e2[j] = p[0][j] - p[2][j];
      end
      n[0] = e1[1] * e2[2] - e1[2] * e2[1];
      n[1] = e2[0] * e1[2] - e2[2] * e1[0];
      n[2] = e2[1] * e1[0] - e2[0] * e1[1];
      mx = 0;
      for (int j = 0; j < 3; j++) begin
        m[j] = n[j] < 0 ? -n[j] : n[j];
        if (m[j] > mx) mx = m[j];
      end
      if (mx == 0) bad = 1;
      r = '0;
      r.kind = KIND_NORMAL;
      r.bad_face = bad;
      if (!bad) begin
        hb = 63;
        while (mx[hb] == 1'b0) hb--;
        for (int j = 0; j < 3; j++)
          m[j] = (hb > 29) ? (m[j] >> (hb - 29)) : (m[j] << (29 - hb));
        sum = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
        d = root64(sum);
        q = (m[0] * 16384 + d / 2) / d;
        r.out_x = FIELD_W'(n[0] < 0 ? -longint'(q) : longint'(q));
        q = (m[1] * 16384 + d / 2) / d;
        r.out_y = FIELD_W'(n[1] < 0 ? -longint'(q) : longint'(q));
        q = (m[2] * 16384 + d / 2) / d;
        r.out_z = FIELD_W'(n[2] < 0 ? -longint'(q) : longint'(q));
      end
      awaited = {awaited, r};
      for (int i = 0; i < 3; i++) begin
        r.kind = KIND_VERTEX;
        r.out_x = FIELD_W'(p[i][0]);
        r.out_y = FIELD_W'(p[i][1]);
        r.out_z = FIELD_W'(p[i][2]);
        r.bad_face = bad;
        r.last = (i == 2);
        awaited = {awaited, r};
      end
    endfunction

    task automatic check(out_item_t got);
      out_item_t w;
      if (awaited.size() == 0) begin
        report($sformatf("unexpected beat %h", got));
        return;
      end
      w = awaited.pop_front();
      if (got.kind !== w.kind)
        report($sformatf("kind %b want %b", got.kind, w.kind));
      if (got.out_x !== w.out_x)
        report($sformatf("out_x %h want %h", got.out_x, w.out_x));
      if (got.out_y !== w.out_y)
        report($sformatf("out_y %h want %h", got.out_y, w.out_y));
      if (got.out_z !== w.out_z)
        report($sformatf("out_z %h want %h", got.out_z, w.out_z));
      if (got.bad_face !== w.bad_face)
        report($sformatf("bad_face %b want %b", got.bad_face, w.bad_face));
      if (got.last !== w.last)
        report($sformatf("last %b want %b", got.last, w.last));
    endtask
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  in_item = '0;
  logic      out_valid;
  out_item_t out_item;
  int        stall_cycles = 0;
  face_normal_board board = new();

  triangle_face_normal_unit dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_valid(out_valid), .out_item(out_item)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) board.check(out_item);
      if ((start && !busy) || out_valid) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  function automatic in_item_t noise_item();
    logic [127:0] raw;
    in_item_t     it;
    raw = {$urandom, $urandom, $urandom, $urandom};
    it = raw[$bits(in_item_t)-1:0];
    return it;
  endfunction

  task send(in_item_t it);
    int gap;
    gap = $urandom_range(0, 19);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_input(it);
  endtask

  task load_vertex(logic [FIELD_W-1:0] x, logic [FIELD_W-1:0] y, logic [FIELD_W-1:0] z);
    in_item_t it;
    it = noise_item();
    it.func = FUNC_VERTEX;
    it.coord_x = x;
    it.coord_y = y;
    it.coord_z = z;
    send(it);
  endtask

  task send_face(logic [IDX_W-1:0] a, logic [IDX_W-1:0] b, logic [IDX_W-1:0] c);
    in_item_t it;
    it = noise_item();
    it.func = FUNC_FACE;
    it.index_a = a;
    it.index_b = b;
    it.index_c = c;
    send(it);
  endtask

  task wait_idle();
    start <= 1'b0;
    while (board.awaited.size() != 0) @(posedge clk);
  endtask

  function automatic logic [IDX_W-1:0] pick_index();
    int k;
    k = $urandom_range(0, 19);
    if (k == 0) return '0;
    if (k == 1) return IDX_W'(board.count + 1);
    if (k == 2) return IDX_W'($urandom);
    return IDX_W'($urandom_range(1, board.count));
  endfunction

  function automatic logic [FIELD_W-1:0] pick_coord();
    if ($urandom_range(0, 2) == 0) return FIELD_W'($urandom_range(0, 8191) - 4096);
    return FIELD_W'($urandom);
  endfunction

  initial begin
    logic [IDX_W-1:0] a;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    load_vertex(24'h800000, 24'h800000, 24'h800000);
    load_vertex(24'h7fffff, 24'h7fffff, 24'h7fffff);
    load_vertex(24'h000000, 24'h000000, 24'h000000);
    load_vertex(24'h001000, 24'h000000, 24'h000000);
    load_vertex(24'h000000, 24'h001000, 24'h000000);
    load_vertex(24'h7fffff, 24'h800000, 24'h000001);
    load_vertex(24'h002000, 24'h000000, 24'h000000);
    send_face(3, 4, 5);
    send_face(3, 5, 4);
    send_face(1, 2, 6);
    send_face(6, 1, 4);
    send_face(0, 1, 2);
    send_face(1, 0, 2);
    send_face(1, 2, 0);
    send_face(1, 2, 8);
    send_face(13'h1fff, 13'h1000, 2);
    send_face(1, 1, 2);
    send_face(3, 4, 7);
    send_face(2, 2, 2);
    send_face(3, 5, 1);

    for (int i = 0; i < 80; i++) begin
      if (i == 40) wait_idle();
      if ($urandom_range(0, 2) == 0) begin
        load_vertex(pick_coord(), pick_coord(), pick_coord());
      end else if ($urandom_range(0, 9) == 0) begin
        a = pick_index();
        send_face(a, a, pick_index());
      end else begin
        send_face(pick_index(), pick_index(), pick_index());
      end
    end

    load_vertex(24'h123456, 24'h654321, 24'h0f0f0f);
    load_vertex(24'h000001, 24'h000002, 24'h000003);
    send_face(13'h1000, 13'h0fff, 1);
    send_face(13'h0ffe, 13'h1000, 13'h1001);
    send_face(13'h1000, 2, 13'h0800);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0 && board.awaited.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
